/* design/psl_pkg.sv */
// Shared types, microcode encoding and control program for the prime sieve lookup.
package psl_pkg;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_FILL  = 3'd1;
  localparam step_t ST_OTEST = 3'd2;
  localparam step_t ST_OREAD = 3'd3;
  localparam step_t ST_INNER = 3'd4;
  localparam step_t ST_NEXTI = 3'd5;
  localparam step_t ST_DONE  = 3'd6;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_START,
    C_JNXT_LT,
    C_SQ_GE,
    C_NOT_PRIME
  } cond_t;

  typedef enum logic [2:0] {
    J_HOLD,
    J_ZERO,
    J_INC,
    J_SQ,
    J_ADDI
  } jsel_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_TWO,
    I_INC
  } isel_t;

  typedef struct packed {
    logic  wr;
    logic  wr_fill;
    logic  rd;
    logic  set_built;
    jsel_t jsel;
    isel_t isel;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic wr_en;
    logic wr_data;
    logic rd_en;
  } map_ctl_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t u;
    u = '{wr: 1'b0, wr_fill: 1'b0, rd: 1'b0, set_built: 1'b0,
          jsel: J_HOLD, isel: I_HOLD, cond: C_NONE, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        u.jsel   = J_ZERO;
        u.cond   = C_NOT_START;
        u.target = ST_IDLE;
      end
      ST_FILL: begin
        u.wr      = 1'b1;
        u.wr_fill = 1'b1;
        u.jsel    = J_INC;
        u.isel    = I_TWO;
        u.cond    = C_JNXT_LT;
        u.target  = ST_FILL;
      end
      ST_OTEST: begin
        u.rd     = 1'b1;
        u.cond   = C_SQ_GE;
        u.target = ST_DONE;
      end
      ST_OREAD: begin
        u.jsel   = J_SQ;
        u.cond   = C_NOT_PRIME;
        u.target = ST_NEXTI;
      end
      ST_INNER: begin
        u.wr     = 1'b1;
        u.jsel   = J_ADDI;
        u.cond   = C_JNXT_LT;
        u.target = ST_INNER;
      end
      ST_NEXTI: begin
        u.isel   = I_INC;
        u.cond   = C_ALWAYS;
        u.target = ST_OTEST;
      end
      ST_DONE: begin
        u.set_built = 1'b1;
        u.cond      = C_ALWAYS;
        u.target    = ST_IDLE;
      end
      default: begin
        u.cond   = C_ALWAYS;
        u.target = ST_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

/* design/psl_if.sv */
// Valid/ready channel interfaces for queries and results.
interface psl_query_if;
  logic        valid;
  logic        ready;
  logic [15:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink (input valid, input query_value, output ready);
endinterface

interface psl_result_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

/* design/psl_map.sv */
// One-bit primality map: one write port, one registered read port.
module psl_map #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/psl_seq.sv */
// Microcoded sequencer that builds the sieve into the primality map.
module psl_seq
  import psl_pkg::*;
#(
  parameter int LIMIT = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     map_rd_data,
  output map_ctl_t                 ctl,
  output logic [$clog2(LIMIT)-1:0] wr_addr,
  output logic [$clog2(LIMIT)-1:0] rd_addr,
  output logic                     built
);

  localparam int AW = $clog2(LIMIT);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LIM_C = CW'(LIMIT);

  step_t          step_r, step_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  sq_r, sq_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic           built_r, built_nxt;
  ucode_t         uc;
  logic           take;

  assign uc = ucode_rom(step_r);

  always_comb begin
    case (uc.jsel)
      J_HOLD:  j_nxt = j_r;
      J_ZERO:  j_nxt = '0;
      J_INC:   j_nxt = j_r + CW'(1);
      J_SQ:    j_nxt = sq_r;
      J_ADDI:  j_nxt = j_r + i_r;
      default: j_nxt = j_r;
    endcase

    case (uc.isel)
      I_HOLD: begin
        i_nxt  = i_r;
        sq_nxt = sq_r;
      end
      I_TWO: begin
        i_nxt  = CW'(2);
        sq_nxt = CW'(4);
      end
      I_INC: begin
        // (i+1)^2 = i^2 + 2i + 1
        i_nxt  = i_r + CW'(1);
        sq_nxt = sq_r + {i_r[CW-2:0], 1'b1};
      end
      default: begin
        i_nxt  = i_r;
        sq_nxt = sq_r;
      end
    endcase

    case (uc.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      // hold in idle once the map is built
      C_NOT_START: take = !start || built_r;
      C_JNXT_LT:   take = (j_nxt < LIM_C);
      C_SQ_GE:     take = (sq_r >= LIM_C);
      C_NOT_PRIME: take = !map_rd_data;
      default:     take = 1'b0;
    endcase

    step_nxt  = take ? uc.target : step_t'(step_r + 3'd1);
    built_nxt = built_r | uc.set_built;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      built_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      built_r <= built_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    sq_r <= sq_nxt;
    j_r  <= j_nxt;
  end

  // Entries 0 and 1 are written as not prime during the fill sweep.
  assign ctl.wr_en   = uc.wr;
  assign ctl.wr_data = uc.wr_fill && (j_r >= CW'(2));
  assign ctl.rd_en   = uc.rd;
  assign wr_addr     = j_r[AW-1:0];
  assign rd_addr     = i_r[AW-1:0];
  assign built       = built_r;

`ifndef SYNTH
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> (j_r < LIM_C))
    else $error("map write beyond the last entry");

  a_built_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |=> built_r)
    else $error("built flag dropped");

  a_no_wr_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> !ctl.wr_en)
    else $error("map written after build finished");
`endif

endmodule

/* design/prime_sieve_lookup.sv */
// Prime sieve lookup: answers whether each query number is prime.
//
// Channels: in_ch carries query_value, out_ch carries is_prime; a request
// moves at a clock edge where valid and ready are both high. Each query
// gives exactly one result; a query at or beyond LIMIT answers 0.
// After reset the map is not built. A pending request on in_ch starts the build
// (in_ch.ready stays low meanwhile): a fill sweep over all LIMIT entries, then
// the sieve, with one map write per cycle in its inner loop, for each candidate
// up to sqrt(LIMIT). The build runs only once.
// Once built, a query costs one map read: the result passes through the map
// read stage and the output register, and one query per cycle is sustained
// while out_ch.ready stays high. The map read stage keeps accepting while a
// finished result waits in the output register; if out_ch.ready stays low
// both fill and in_ch.ready drops until the receiver takes the result. Reset
// (rst_n, synchronous, active low) clears the built flag and the pipeline
// valids.
module prime_sieve_lookup
  import psl_pkg::*;
#(
  parameter int LIMIT = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  psl_query_if.sink    in_ch,
  psl_result_if.source out_ch
);

  localparam int AW = $clog2(LIMIT);

  map_ctl_t        seq_ctl;
  logic [AW-1:0]   seq_wr_addr;
  logic [AW-1:0]   seq_rd_addr;
  logic            built;
  logic            map_rd_en;
  logic [AW-1:0]   map_rd_addr;
  logic            map_rd_data;
  logic            accept;
  logic            in_range;
  logic            s1_move;
  logic            s1_v_r, s1_v_nxt;
  logic            s1_in_r;
  logic            out_v_r, out_v_nxt;
  logic            out_bit_r;

  psl_seq #(.LIMIT(LIMIT)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_ch.valid),
    .map_rd_data (map_rd_data),
    .ctl         (seq_ctl),
    .wr_addr     (seq_wr_addr),
    .rd_addr     (seq_rd_addr),
    .built       (built)
  );

  psl_map #(.DEPTH(LIMIT)) u_map (
    .clk     (clk),
    .wr_en   (seq_ctl.wr_en),
    .wr_addr (seq_wr_addr),
    .wr_data (seq_ctl.wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  assign in_range = (32'(in_ch.query_value) < 32'(LIMIT));
  assign s1_move  = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = built && (!s1_v_r || s1_move);
  assign accept   = in_ch.valid && in_ch.ready;

  // Out-of-range queries skip the read so the map is never addressed past its end.
  assign map_rd_en   = (accept && in_range) || seq_ctl.rd_en;
  assign map_rd_addr = built ? AW'(in_ch.query_value) : seq_rd_addr;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_r <= in_range;
    end
    if (s1_move) begin
      out_bit_r <= s1_in_r && map_rd_data;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.is_prime = out_bit_r;

`ifndef SYNTH
  a_accept_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> built)
    else $error("request accepted before the map was built");

  a_no_ready_before_build: assert property (@(posedge clk) disable iff (!rst_n)
    !built |-> !in_ch.ready)
    else $error("input ready before the map was built");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.is_prime)))
    else $error("result changed while stalled");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench for prime_sieve_lookup: random and directed queries checked against a local sieve.
`timescale 1ns / 1ps

module tb_top;

  localparam int          MAP_SIZE   = 65536;
  localparam int unsigned CYCLE_CAP  = 1_200_000;
  localparam int          RAND_COUNT = 400;
  localparam int          DRAIN_WAIT = 8;

  // Directed: zero and one, small primes and composites, squares of primes,
  // the field extremes and the largest prime below the map size.
  localparam logic [15:0] DIRECTED_QUERIES [22] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd25, 16'd97, 16'd255,
    16'd256, 16'd257, 16'd63001, 16'd65025, 16'd65519, 16'd65521,
    16'd65533, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA, 16'h8000,
    16'h7FFF
  };

  typedef struct {
    logic [15:0] query_value;
    logic        is_prime;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  psl_query_if  q_ch ();
  psl_result_if r_ch ();

  prime_sieve_lookup #(.LIMIT(MAP_SIZE)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (q_ch),
    .out_ch (r_ch)
  );

  always #4 clk = ~clk;

  bit            prime_table [0:MAP_SIZE-1];
  bit            table_built;
  logic [15:0]   query_backlog[$];
  answer_t       answers_due[$];
  int unsigned   err_count;
  int unsigned   cycle_count;
  int unsigned   send_calm;
  int unsigned   recv_calm;
  int unsigned   send_gap;
  int unsigned   recv_stall;

  // Sieve of Eratosthenes over the whole map, run once on first use.
  function automatic void build_prime_table();
    longint unsigned i;
    longint unsigned j;
    for (int k = 0; k < MAP_SIZE; k++) prime_table[k] = 1'b1;
    prime_table[0] = 1'b0;
    prime_table[1] = 1'b0;
    for (i = 2; i * i < MAP_SIZE; i++) begin
      if (prime_table[i]) begin
        for (j = i * i; j < MAP_SIZE; j += i) prime_table[j] = 1'b0;
      end
    end
    table_built = 1'b1;
  endfunction

  function automatic logic predict_is_prime(input logic [15:0] q);
    if (!table_built) build_prime_table();
    if (int'(q) >= MAP_SIZE) return 1'b0;
    return prime_table[q];
  endfunction

  // Draws a random wait, with occasional stretches of no waiting.
  function automatic int unsigned draw_wait(ref int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Driver: present backlog requests, record the expected answer on acceptance.
  always @(posedge clk) begin
    answer_t a;
    logic    fire;
    if (!rst_n) begin
      q_ch.valid       <= 1'b0;
      q_ch.query_value <= '0;
      send_gap = draw_wait(send_calm);
    end else begin
      fire = q_ch.valid && q_ch.ready;
      if (fire) begin
        a.query_value = q_ch.query_value;
        a.is_prime    = predict_is_prime(q_ch.query_value);
        answers_due = {answers_due, a};
      end
      if (!q_ch.valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          q_ch.valid <= 1'b0;
        end else if (query_backlog.size() > 0) begin
          q_ch.valid       <= 1'b1;
          q_ch.query_value <= query_backlog.pop_front();
          send_gap = draw_wait(send_calm);
        end else begin
          q_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expected answer.
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      r_ch.ready <= 1'b0;
      recv_stall = draw_wait(recv_calm);
    end else begin
      if (r_ch.valid && r_ch.ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: is_prime actual %0b", r_ch.is_prime);
          err_count++;
        end else begin
          a = answers_due.pop_front();
          if (r_ch.is_prime !== a.is_prime) begin
            $error("is_prime mismatch for query %0d: expected %0b actual %0b",
                   a.query_value, a.is_prime, r_ch.is_prime);
            err_count++;
          end
        end
        recv_stall = draw_wait(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        r_ch.ready <= 1'b0;
      end else begin
        r_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] v;
    int unsigned pick;
    q_ch.valid       = 1'b0;
    q_ch.query_value = '0;
    r_ch.ready       = 1'b0;
    rst_n            = 1'b0;

    foreach (DIRECTED_QUERIES[k])
      query_backlog = {query_backlog, DIRECTED_QUERIES[k]};

    for (int n = 0; n < RAND_COUNT; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        v = $urandom_range(0, 65535);
      end else if (pick < 60) begin
        v = $urandom_range(0, 400);
      end else if (pick < 85) begin
        // advance to the next prime so positive answers are frequent
        v = $urandom_range(0, 65535);
        while (!predict_is_prime(v)) v = (v == 16'hFFFF) ? 16'd2 : v + 16'd1;
      end else begin
        v = $urandom_range(65000, 65535);
      end
      query_backlog = {query_backlog, v};
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (query_backlog.size() > 0 || q_ch.valid) @(posedge clk);
    while (answers_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (answers_due.size() != 0) begin
      $error("%0d expected results never arrived", answers_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
